// ===== rtl/lir_pkg.sv =====
// Package for the linear interpolation resampler: word types, sequencer states,
// field widths and constants. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package lir_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STEP_BITS = 29;
  localparam int PCM_BITS = 16;

  localparam int FRAC_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF = 32;
  localparam int MAX_RUN_DEF = 16;

  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(16777216);

  localparam int PCM_MAX = 32767;
  localparam int PCM_MIN = -32768;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef struct packed {
    logic kind;
    logic signed [SAMPLE_BITS-1:0] sample;
  } lir_in_t;

  typedef struct packed {
    logic signed [PCM_BITS-1:0] pcm;
    logic last_of_run;
    logic stream_done;
  } lir_out_t;

  typedef struct packed {
    logic mul_en;
    logic rnd_en;
  } lir_interp_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_MUL,
    ST_RND,
    ST_PUSH
  } lir_state_t;

endpackage

// ===== rtl/lir_interp.sv =====
// Shared interpolation unit: one registered multiply, then rounding half to even
// and saturation to 16 bits in a second registered step. Depends on lir_pkg.
`timescale 1ns / 1ps

module lir_interp
  import lir_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  lir_interp_ctl_t               ctl,
  input  logic signed [SAMPLE_BITS-1:0] left,
  input  logic signed [SAMPLE_BITS-1:0] right,
  input  logic        [FRAC_BITS-1:0]   frac,
  output logic signed [PCM_BITS-1:0]    pcm
);

  localparam int V_W = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int SH = FRAC_BITS + SAMPLE_BITS - 18;
  localparam int Q_W = V_W - SH;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [V_W-1:0]         product;
  logic signed [V_W-1:0]         prod_r;
  logic signed [SAMPLE_BITS-1:0] left_r;
  logic signed [V_W-1:0]         value;
  logic signed [Q_W-1:0]         quot;
  logic        [SH-1:0]          rem;
  logic                          round_up;
  logic signed [Q_W:0]           rounded;
  logic signed [PCM_BITS-1:0]    pcm_next;

  assign diff = (SAMPLE_BITS + 1)'(right) - (SAMPLE_BITS + 1)'(left);
  assign product = diff * $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= product;
      left_r <= left;
    end
  end

  // Floor division by a power of two is an arithmetic shift; the remainder is the
  // low bits that fall away.
  assign value = (V_W'(left_r) <<< FRAC_BITS) + prod_r;
  assign quot = Q_W'(value >>> SH);
  assign rem = value[SH-1:0];
  assign round_up = (rem > {1'b1, {(SH-1){1'b0}}}) ||
                    ((rem == {1'b1, {(SH-1){1'b0}}}) && quot[0]);
  assign rounded = (Q_W + 1)'(quot) + $signed({{Q_W{1'b0}}, round_up});

  always_comb begin
    if (rounded > (Q_W + 1)'(PCM_MAX)) begin
      pcm_next = PCM_BITS'(PCM_MAX);
    end else if (rounded < (Q_W + 1)'(PCM_MIN)) begin
      pcm_next = PCM_BITS'(PCM_MIN);
    end else begin
      pcm_next = rounded[PCM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rnd_en) begin
      pcm <= pcm_next;
    end
  end

endmodule

// ===== rtl/linear_interp_resampler_s16.sv =====
// Top level of the linear interpolation resampler: sequencer, stream state and
// output register. Depends on lir_pkg and lir_interp.
`timescale 1ns / 1ps

// Each accepted word is a sample or the end-of-stream mark, and yields from zero
// to MAX_RUN output words. Each input word passes through acceptance, state update
// and the emission test, and each output then passes in turn through the shared
// multiplier, the rounding and saturation step and the output register; a stalled
// output register holds the sequence. No new word is accepted until the sequence
// for the previous word has finished. While step_ratio is zero, words are accepted
// and dropped without leaving the idle state.

module linear_interp_resampler_s16
  import lir_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [STEP_BITS-1:0] cfg_wdata,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  lir_in_t              sample_word,
  output logic                 result_valid,
  input  logic                 result_ready,
  output lir_out_t             result_word
);

  localparam int POS_W = COUNT_BITS + FRAC_BITS + 1;
  localparam int RUN_W = $clog2(MAX_RUN + 1);

  lir_state_t state, state_next;
  lir_interp_ctl_t ctl;

  logic [STEP_BITS-1:0]          step_ratio;
  logic                          in_kind;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [SAMPLE_BITS-1:0] older_sample;
  logic signed [SAMPLE_BITS-1:0] newest_sample;
  logic [COUNT_BITS-1:0]         samples_seen;
  logic [POS_W-1:0]              out_position;
  logic                          ended;
  logic [RUN_W-1:0]              run_cnt;

  logic [POS_W:0]                pos_sum;
  logic [COUNT_BITS:0]           idx;
  logic [COUNT_BITS+1:0]         idx_p1;
  logic [COUNT_BITS+1:0]         idx_p2;
  logic [COUNT_BITS+1:0]         seen_x;
  logic                          may_emit;
  logic                          more;
  logic                          out_free;
  logic                          push_en;
  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] left;
  logic signed [SAMPLE_BITS-1:0] right;
  logic signed [PCM_BITS-1:0]    pcm;

  assign accept = sample_valid && sample_ready;
  assign out_free = !result_valid || result_ready;

  // One adder serves both the phase advance and the tail test.
  assign pos_sum = {1'b0, out_position} + (POS_W + 1)'(step_ratio);
  assign idx = out_position[POS_W-1:FRAC_BITS];
  assign idx_p1 = {1'b0, idx} + (COUNT_BITS + 2)'(1);
  assign idx_p2 = {1'b0, idx} + (COUNT_BITS + 2)'(2);
  assign seen_x = {2'b00, samples_seen};

  always_comb begin
    if (ended) begin
      may_emit = pos_sum <= {2'b00, samples_seen, {FRAC_BITS{1'b0}}};
    end else if ({1'b0, idx} >= seen_x) begin
      may_emit = 1'b0;
    end else begin
      may_emit = (out_position[FRAC_BITS-1:0] == '0) || (idx_p1 < seen_x);
    end
  end

  assign more = (run_cnt < RUN_W'(MAX_RUN)) && may_emit;
  assign left = (idx_p1 >= seen_x) ? newest_sample : older_sample;
  assign right = (idx_p2 >= seen_x) ? newest_sample : older_sample;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (step_ratio != '0)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_CHECK;
      ST_CHECK: state_next = may_emit ? ST_MUL : ST_IDLE;
      ST_MUL: state_next = ST_RND;
      ST_RND: state_next = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          state_next = more ? ST_MUL : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    ctl = '0;
    push_en = 1'b0;
    case (state)
      ST_IDLE: sample_ready = 1'b1;
      ST_MUL: ctl.mul_en = 1'b1;
      ST_RND: ctl.rnd_en = 1'b1;
      ST_PUSH: push_en = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= STEP_RESET;
    end else if (cfg_we) begin
      step_ratio <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind <= sample_word.kind;
      in_sample <= sample_word.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample <= '0;
      newest_sample <= '0;
      samples_seen <= '0;
      out_position <= '0;
      ended <= 1'b0;
      run_cnt <= '0;
    end else begin
      if (state == ST_LOAD) begin
        run_cnt <= '0;
        if (!ended) begin
          if (in_kind == KIND_SAMPLE) begin
            if (samples_seen != '1) begin
              older_sample <= newest_sample;
              newest_sample <= in_sample;
              samples_seen <= samples_seen + COUNT_BITS'(1);
            end
          end else begin
            ended <= 1'b1;
          end
        end
      end
      if (state == ST_RND) begin
        out_position <= pos_sum[POS_W-1:0];
        run_cnt <= run_cnt + RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push_en) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      result_word.pcm <= pcm;
      result_word.last_of_run <= !more;
      result_word.stream_done <= ended && !may_emit;
    end
  end

  lir_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk  (clk),
    .ctl  (ctl),
    .left (left),
    .right(right),
    .frac (out_position[FRAC_BITS-1:0]),
    .pcm  (pcm)
  );

  // The word that closes the tail also closes its run.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.stream_done |-> result_word.last_of_run)
    else $error("stream_done without last_of_run");

  // A tail can only be closed once the end mark has been taken in.
  a_done_after_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.stream_done |-> ended)
    else $error("stream_done before end of stream");

  // No run exceeds its limit.
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_cnt <= RUN_W'(MAX_RUN))
    else $error("run counter beyond limit");

  // An output word is only loaded after the rounding step, possibly after a stall in the push state.
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push_en |-> ($past(state) == ST_RND) || ($past(state) == ST_PUSH))
    else $error("output loaded out of sequence");

endmodule
